// ----- hw/rtl/dfsc_pkg.sv -----
package dfsc_pkg;

  localparam int unsigned MaxRows  = 512;
  localparam int unsigned MaxCols  = 512;
  localparam int unsigned WinSide  = 20;
  localparam int unsigned WinHalf  = 10;
  localparam int unsigned WinSize  = 400;
  localparam int unsigned RankLo   = 200;
  localparam int unsigned RankHi   = 300;
  localparam int unsigned RankCnt  = 100;
  localparam int unsigned WinAw    = $clog2(WinSize);
  localparam int unsigned PosW     = 13;

  localparam logic [1:0] RegRows   = 2'd0;
  localparam logic [1:0] RegCols   = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] depth_in;
  } in_req_t;

  typedef struct packed {
    logic [15:0] value_out;
    logic        is_nose_estimate;
    logic        last_pixel;
  } out_req_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic pix_step;     // process the held pixel
    logic cnt_clear;    // clear rank counter / accumulators
    logic scan_step;    // one step of the rank scan
    logic nose_load;    // latch finished average as nose
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic frame_end;
    logic scan_done;
  } dp_sts_t;

endpackage

// ----- hw/rtl/dfsc_ram.sv -----
module dfsc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 400
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/dfsc_ctrl.sv -----
module dfsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_func_i,
  input  logic              out_busy_i,
  output logic              emit_o,
  input  dfsc_pkg::dp_sts_t sts_i,
  output dfsc_pkg::dp_cmd_t cmd_o
);
  import dfsc_pkg::*;

  typedef enum logic [1:0] {StIdle, StScan, StNose} state_e;
  state_e state_q;

  logic take;
  assign in_ready_o = (state_q == StIdle) && !out_busy_i;
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    emit_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        cmd_o.pix_step = take;
        cmd_o.cnt_clear = take;
        emit_o = take && in_func_i;
      end
      StScan: cmd_o.scan_step = 1'b1;
      StNose: begin
        // The nose result waits until the output register is free.
        cmd_o.nose_load = !out_busy_i;
        emit_o = !out_busy_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (take && !in_func_i && sts_i.frame_end) state_q <= StScan;
        StScan: if (sts_i.scan_done) state_q <= StNose;
        StNose: if (!out_busy_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  a_emit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> !out_busy_i) else $error("emit while output full");
  a_nose_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNose) |-> $past(state_q != StIdle)) else $error("bad nose entry");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready during scan");

endmodule

// ----- hw/rtl/dfsc_datapath.sv -----
module dfsc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [9:0]        cfg_data_i,
  input  dfsc_pkg::in_req_t in_i,
  input  dfsc_pkg::dp_cmd_t cmd_i,
  output dfsc_pkg::dp_sts_t sts_o,
  output logic [15:0]       crop_o,
  output logic [15:0]       nose_o
);
  import dfsc_pkg::*;

  logic [9:0] rows_q, cols_q;
  logic [7:0] rad_q;
  logic [8:0] row_q, col_q;
  logic [15:0] nose_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 10'd424;
      cols_q <= 10'd512;
      rad_q  <= 8'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRows:   rows_q <= cfg_data_i;
        RegCols:   cols_q <= cfg_data_i;
        RegRadius: rad_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [9:0] rows, cols;
  assign rows = (rows_q < 10'd20) ? 10'd20 : (rows_q > 10'(MaxRows)) ? 10'(MaxRows) : rows_q;
  assign cols = (cols_q < 10'd20) ? 10'd20 : (cols_q > 10'(MaxCols)) ? 10'(MaxCols) : cols_q;

  logic [8:0] cr, cc;
  assign cr = rows[9:1];
  assign cc = cols[9:1];

  logic line_end, frame_end;
  assign line_end  = {1'b0, col_q} >= cols - 10'd1;
  assign frame_end = line_end && ({1'b0, row_q} >= rows - 10'd1);
  assign sts_o.frame_end = frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.pix_step) begin
      if (frame_end) begin
        row_q <= '0;
        col_q <= '0;
      end else if (line_end) begin
        col_q <= '0;
        row_q <= row_q + 9'd1;
      end else begin
        col_q <= col_q + 9'd1;
      end
    end
  end

  // Window write. Rows above or columns left of the window wrap to large offsets and fail the in-window check.
  logic [9:0] wr_off, wc_off;
  logic in_win;
  assign wr_off = {1'b0, row_q} - {1'b0, cr} + 10'(WinHalf);
  assign wc_off = {1'b0, col_q} - {1'b0, cc} + 10'(WinHalf);
  assign in_win = (wr_off < 10'(WinSide)) && (wc_off < 10'(WinSide));
  logic [WinAw-1:0] waddr;
  assign waddr = WinAw'(wr_off[4:0]) * WinAw'(WinSide) + WinAw'(wc_off[4:0]);

  // Rank scan: for each entry i, count entries j with (v_j,j) < (v_i,i).
  // Its rank is unique; ranks 200..299 are summed. Per entry i, step 0
  // reads entry i, step 1 holds it and reads entry 0, and steps 2..401
  // compare entry step-2 against it.
  logic [WinAw-1:0] i_q, step_q, jd, raddr;
  logic [WinAw:0]   rank_q, rank_nx;
  logic [15:0]      vi_q;
  logic [23:0]      sum_q;
  logic             done_q;
  logic [15:0]      rdata;
  logic             less;

  assign raddr = (step_q == '0 || step_q == WinAw'(WinSize + 1)) ? i_q :
                 step_q - WinAw'(1);
  assign jd    = step_q - WinAw'(2);

  dfsc_ram #(.Width(16), .Depth(WinSize)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.pix_step && !in_i.func && in_win),
    .waddr_i(waddr),
    .wdata_i(in_i.depth_in),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign less    = (rdata < vi_q) || ((rdata == vi_q) && (jd < i_q));
  assign rank_nx = rank_q + (WinAw+1)'(less);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; step_q <= '0; rank_q <= '0; vi_q <= '0; sum_q <= '0; done_q <= 1'b0;
    end else if (cmd_i.cnt_clear) begin
      i_q <= '0; step_q <= '0; rank_q <= '0; sum_q <= '0; done_q <= 1'b0;
    end else if (cmd_i.scan_step && !done_q) begin
      if (step_q == WinAw'(WinSize + 1)) begin
        if (rank_nx >= (WinAw+1)'(RankLo) && rank_nx < (WinAw+1)'(RankHi))
          sum_q <= sum_q + 24'(vi_q);
        step_q <= '0;
        if (i_q == WinAw'(WinSize - 1)) done_q <= 1'b1;
        else i_q <= i_q + WinAw'(1);
      end else begin
        step_q <= step_q + WinAw'(1);
        if (step_q == WinAw'(1)) begin
          vi_q <= rdata;
          rank_q <= '0;
        end else if (step_q != '0) begin
          rank_q <= rank_nx;
        end
      end
    end
  end
  assign sts_o.scan_done = done_q;

  // Divide by 100: the sum stays below 2^23. A reciprocal multiply gives the
  // quotient or one less; the remainder check corrects it.
  logic [47:0] prod;
  logic [15:0] q0_q;
  logic [23:0] rem;
  logic [15:0] nose_d;
  assign prod = 48'(sum_q) * 48'd10737418;   // floor(2^30/100)

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q0_q <= '0;
    else q0_q <= prod[45:30];
  end

  assign rem    = sum_q - 24'(q0_q) * 24'd100;
  assign nose_d = (rem >= 24'd100) ? q0_q + 16'd1 : q0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nose_q <= '0;
    else if (cmd_i.nose_load) nose_q <= nose_d;
  end
  assign nose_o = nose_d;

  // Crop distance from absolute offsets.
  logic [8:0]  adr, adc;
  logic [15:0] add;
  logic [17:0] dr2, dc2;
  logic [31:0] dd2;
  logic [33:0] sq_dist;
  logic [15:0] lim;
  assign adr = (cr >= row_q) ? cr - row_q : row_q - cr;
  assign adc = (cc >= col_q) ? cc - col_q : col_q - cc;
  assign add = (in_i.depth_in >= nose_q) ? in_i.depth_in - nose_q : nose_q - in_i.depth_in;
  assign dr2 = 18'(adr) * 18'(adr);
  assign dc2 = 18'(adc) * 18'(adc);
  assign dd2 = 32'(add) * 32'(add);
  assign sq_dist = 34'(dr2) + 34'(dc2) + 34'(dd2);
  assign lim = 16'(rad_q) * 16'(rad_q);
  assign crop_o = (sq_dist <= 34'(lim)) ?
                  16'({nose_q, 1'b0} - {1'b0, in_i.depth_in}) : 16'd0;

  a_done_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !cmd_i.cnt_clear) |=> done_q) else $error("done dropped");
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> rank_q <= (WinAw+1)'(WinSize)) else $error("rank overflow");
  a_no_pix_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> !cmd_i.pix_step) else $error("pixel during scan");

endmodule

// ----- hw/rtl/depth_face_sphere_crop_core.sv -----
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   dfsc_pkg::in_req_t
// out       output     out_valid_o/out_ready_i dfsc_pkg::out_req_t
// cfg       input      cfg_we_i (no wait)      index + 10-bit data
//
// One pixel is taken per cycle while the output register is free or empties.
// The last first-pass pixel starts a rank scan of the 400-entry window memory,
// one entry after another; the average then settles and is emitted as the
// nose once the output register is free; no request is taken meanwhile.
// Reset is asynchronous and active low; the window memory is not cleared.
// A result waiting in the output register stalls the input side.
module depth_face_sphere_crop_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dfsc_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dfsc_pkg::out_req_t out_data_o
);
  import dfsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic emit;
  logic [15:0] crop, nose;
  logic out_busy;

  // The output register frees in the same cycle its request is taken.
  assign out_busy = out_valid_o && !out_ready_i;

  dfsc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_func_i(in_data_i.func), .out_busy_i(out_busy),
    .emit_o(emit), .sts_i(sts), .cmd_o(cmd)
  );

  dfsc_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .crop_o(crop), .nose_o(nose)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // The datapath presents the average being latched as the nose, so both
  // kinds of request leave through the same register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_o.value_out        <= cmd.nose_load ? nose : crop;
      out_data_o.is_nose_estimate <= cmd.nose_load;
      out_data_o.last_pixel       <= !cmd.nose_load && sts.frame_end;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result lost");
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_o && !out_ready_i)) else $error("overwrite");
  a_nose_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_nose_estimate) |-> !out_data_o.last_pixel)
    else $error("flag clash");

endmodule

// ----- bench/dfsc_crop_checker.sv -----
module dfsc_crop_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  dfsc_pkg::in_req_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  dfsc_pkg::out_req_t out_data_i,
  output int                 fails_o,
  output int                 pending_o
);
  import dfsc_pkg::*;

  logic [15:0] window_q [WinSize];
  int          row_q;
  int          col_q;
  logic [15:0] nose_q;
  logic [9:0]  rows_cfg;
  logic [9:0]  cols_cfg;
  logic [7:0]  radius_cfg;
  out_req_t    expected_pixels [$];
  out_req_t    oldest;

  function automatic int clamp_dim(int v, int hi);
    if (v < 20) return 20;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mean of the middle hundred ranks of the window, truncated.
  function automatic logic [15:0] ranked_mean();
    logic [15:0] vals [WinSize];
    logic [15:0] v;
    int          j;
    int unsigned sum;
    vals = window_q;
    sum = 0;
    for (int i = 1; i < WinSize; i++) begin
      v = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > v) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = v;
    end
    for (int i = RankLo; i < RankHi; i++) sum += vals[i];
    return 16'(sum / RankCnt);
  endfunction

  task automatic predict_crop(input in_req_t req);
    int       rows;
    int       cols;
    int       cr;
    int       cc;
    int       idx;
    bit       line_end;
    bit       frame_end;
    longint   sq_dist;
    out_req_t res;
    rows = clamp_dim(int'(rows_cfg), MaxRows);
    cols = clamp_dim(int'(cols_cfg), MaxCols);
    cr = rows / 2;
    cc = cols / 2;
    line_end = col_q >= cols - 1;
    frame_end = line_end && row_q >= rows - 1;
    if (!req.func) begin
      if (row_q >= cr - WinHalf && row_q < cr + WinHalf &&
          col_q >= cc - WinHalf && col_q < cc + WinHalf) begin
        idx = (row_q - (cr - WinHalf)) * WinSide + (col_q - (cc - WinHalf));
        window_q[idx] = req.depth_in;
      end
      if (frame_end) begin
        nose_q = ranked_mean();
        res.value_out = nose_q;
        res.is_nose_estimate = 1'b1;
        res.last_pixel = 1'b0;
        expected_pixels.insert(expected_pixels.size(), res);
      end
    end else begin
      sq_dist = longint'(cr - row_q) * longint'(cr - row_q)
              + longint'(cc - col_q) * longint'(cc - col_q)
              + (longint'(req.depth_in) - longint'(nose_q))
              * (longint'(req.depth_in) - longint'(nose_q));
      res.value_out = 16'd0;
      if (sq_dist <= longint'(radius_cfg) * longint'(radius_cfg))
        res.value_out = {nose_q[14:0], 1'b0} - req.depth_in;
      res.is_nose_estimate = 1'b0;
      res.last_pixel = frame_end;
      expected_pixels.insert(expected_pixels.size(), res);
    end
    if (frame_end) begin
      row_q = 0;
      col_q = 0;
    end else if (line_end) begin
      col_q = 0;
      row_q++;
    end else begin
      col_q++;
    end
  endtask

  task automatic note_mismatch(input string why, input out_req_t want, input out_req_t got);
    fails_o++;
    if (fails_o <= 10)
      $display("%0t: %s: expected value %0d nose %0b last %0b, got value %0d nose %0b last %0b",
               $realtime, why, want.value_out, want.is_nose_estimate, want.last_pixel,
               got.value_out, got.is_nose_estimate, got.last_pixel);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q = 0;
      col_q = 0;
      nose_q = 16'd0;
      rows_cfg = 10'd424;
      cols_cfg = 10'd512;
      radius_cfg = 8'd80;
      expected_pixels.delete();
      fails_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("unexpected result", '0, out_data_i);
        end else begin
          oldest = expected_pixels.pop_front();
          if (oldest !== out_data_i) note_mismatch("result mismatch", oldest, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_crop(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRows:   rows_cfg = cfg_data_i;
          RegCols:   cols_cfg = cfg_data_i;
          RegRadius: radius_cfg = cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import dfsc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = RegRows;
  logic [9:0] cfg_data = 10'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_req_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_req_t   out_data;
  int         fails;
  int         pending;

  // Mirror of the raster position and sizes, kept so the stimulus knows
  // which request closes a frame. Each first-pass frame end starts a long rank
  // scan, so only three of them are allowed.
  int          rows_now = 424;
  int          cols_now = 512;
  int          pos_row = 0;
  int          pos_col = 0;
  int          scans_left = 3;
  int          sent_total = 0;
  int          results_seen = 0;
  logic [15:0] last_nose = 16'd0;
  bit          calm = 1'b0;

  depth_face_sphere_crop_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  dfsc_crop_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The run covers a handful of rank scans plus about a thousand pixels,
  // each with the longest gaps on both sides; this limit is far above that.
  initial begin
    #30000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Remember the latest nose estimate so that second-pass depths can be
  // drawn close to it and actually land inside the keep sphere.
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (out_data.is_nose_estimate) last_nose <= out_data.value_out;
    end
  end

  function automatic int clamp_dim(int v);
    if (v < 20) return 20;
    if (v > 512) return 512;
    return v;
  endfunction

  // Mostly a depth near the current nose, now and then any 16-bit value.
  function automatic logic [15:0] pick_depth(int offset, int spread);
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    return 16'(int'(last_nose) + offset + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Waits until every expected result has come back, then lets a first-pass
  // pixel that gives no result settle.
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges; only called when idle.
  task automatic set_config(int rows, int cols, int radius);
    cfg_we <= 1'b1;
    cfg_idx <= RegRows;
    cfg_data <= 10'(rows);
    @(posedge clk_i);
    cfg_idx <= RegCols;
    cfg_data <= 10'(cols);
    @(posedge clk_i);
    cfg_idx <= RegRadius;
    cfg_data <= 10'(radius);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rows_now = rows;
    cols_now = cols;
  endtask

  // Streams pixels; pct_first is the share of first-pass requests. A frame
  // end is sent as a first-pass request only while rank scans remain.
  task automatic send_pixels(int count, int pct_first, int offset, int spread);
    int gap;
    bit line_end;
    bit frame_end;
    bit first;
    for (int n = 0; n < count; n++) begin
      if (sent_total % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      line_end = pos_col >= clamp_dim(cols_now) - 1;
      frame_end = line_end && pos_row >= clamp_dim(rows_now) - 1;
      first = $urandom_range(0, 99) < pct_first;
      if (frame_end && first) begin
        if (scans_left == 0) first = 1'b0;
        else scans_left--;
      end
      in_valid <= 1'b1;
      in_data <= '{func: !first, depth_in: pick_depth(offset, spread)};
      do @(posedge clk_i); while (!in_ready);
      sent_total++;
      if (frame_end) begin
        pos_row = 0;
        pos_col = 0;
      end else if (line_end) begin
        pos_col = 0;
        pos_row++;
      end else begin
        pos_col++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: a random hold-off per result, idle-free stretches, and one
  // long hold once traffic is flowing so the block backs up to its input.
  initial begin
    int  gap;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && results_seen >= 300) begin
        gap = 400;
        long_hold_done = 1'b1;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    int rows;
    int cols;
    int radius;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A full 20x20 first pass fills the whole window with small depths, so
    // the nose is low and folding around it wraps below zero.
    set_config(20, 20, 80);
    send_pixels(400, 100, 60, 40);
    settle();

    // Widest sphere, then the largest sizes (clamped) partway into a frame.
    set_config(20, 20, 255);
    send_pixels(60, 0, 0, 300);
    settle();
    set_config(1023, 1023, 255);
    send_pixels(30, 50, 0, 300);
    settle();

    // Sizes shrink mid-frame, and a zero radius keeps only the centre pixel
    // whose depth equals the nose; most depths here are drawn at the nose itself.
    set_config(0, 20, 0);
    send_pixels(340, 30, 0, 0);
    settle();

    // Random phases: mostly small frames, now and then the extreme sizes.
    while (sent_total < 1050) begin
      rows = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 1023 : 0)
                                         : $urandom_range(20, 24);
      cols = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 1023 : 0)
                                         : $urandom_range(20, 24);
      radius = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(1, 255);
      set_config(rows, cols, radius);
      send_pixels(60, 15, 0, radius + 20);
      settle();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- depth_face_sphere_crop_core.f -----
hw/rtl/dfsc_pkg.sv
hw/rtl/dfsc_ram.sv
hw/rtl/dfsc_ctrl.sv
hw/rtl/dfsc_datapath.sv
hw/rtl/depth_face_sphere_crop_core.sv
bench/dfsc_crop_checker.sv
bench/tb_top.sv
